### rtl/prqw_pkg.sv
// Shared constants and register codes for the phase residue and quality window.
package prqw_pkg;

    // Phase word: 2^PHASE_BITS stands for a full turn.
    localparam int PHASE_BITS = 16;
    localparam int PHASE_IN_W = 16;

    // Line store geometry.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Configuration port.
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 1;
    localparam int WX_W    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int HX_W    = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;
    localparam int FRAME_WIDTH_RST  = 1024;
    localparam int FRAME_HEIGHT_RST = 1024;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    // Result widths.
    localparam int RES_W  = 3;
    localparam int CURL_W = PHASE_BITS + 2;
    localparam int SQ_W   = 2 * PHASE_BITS;
    localparam int Q_W    = 33;
    localparam int SAT_W  = (2 * PHASE_BITS + 1 > Q_W + 1) ? 2 * PHASE_BITS + 1 : Q_W + 1;

endpackage

### rtl/phase_residue_quality_window.sv
// Phase residue and second-difference quality over a 3x3 raster window.
//
// Pixels stream in raster order, one per cycle sustained while out_stall is low; each
// accepted pixel gives one result beat (input stage with line-store read, then result
// register). The rate is set by the line store: a single memory of MAX_WIDTH words
// holding the two previous rows side by side, read once at pixel entry and written
// once as the pixel leaves the input stage. residue is the curl of the 2x2 cell whose
// bottom-right corner is the current pixel; quality_sum belongs to the pixel one row and
// one column back. Both read as zero where their valid flag is low. Width and height
// are saturated to 3..MAX_WIDTH and 3..1024 and should be written only while idle;
// the line store is not cleared, so the first row's neighbors above are never used.
module phase_residue_quality_window
(
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [prqw_pkg::PHASE_IN_W-1:0]     phase,
    // result output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [prqw_pkg::RES_W-1:0]   residue,
    output logic                                residue_valid,
    output logic [prqw_pkg::Q_W-1:0]            quality_sum,
    output logic                                quality_valid,
    output logic                                frame_end,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prqw_pkg::IDX_W-1:0]          cfg_index,
    input  logic [prqw_pkg::CFG_W-1:0]          cfg_data
);

    localparam int PB = prqw_pkg::PHASE_BITS;

    function automatic logic signed [PB-1:0] phase_delta(
        input logic [PB-1:0] a,
        input logic [PB-1:0] b
    );
        logic [PB-1:0] d;
        d = a - b;
        return $signed(d);
    endfunction

    // wrap(wrap(c-b) - wrap(b-a)) is simply (c - 2b + a) modulo the phase word
    function automatic logic [prqw_pkg::SQ_W-1:0] sd_square(
        input logic [PB-1:0] a,
        input logic [PB-1:0] b,
        input logic [PB-1:0] c
    );
        logic [PB-1:0] d;
        logic [PB-1:0] mag;
        d   = c - b - b + a;
        mag = d[PB-1] ? (~d + PB'(1)) : d;
        return prqw_pkg::SQ_W'(mag) * prqw_pkg::SQ_W'(mag);
    endfunction

    // configuration
    logic [prqw_pkg::CFG_W-1:0] frame_width_reg;
    logic [prqw_pkg::CFG_W-1:0] frame_height_reg;
    logic [prqw_pkg::WX_W-1:0]  w_eff;
    logic [prqw_pkg::HX_W-1:0]  h_eff;
    logic [prqw_pkg::WX_W-1:0]  fw_x;
    logic [prqw_pkg::HX_W-1:0]  fh_x;

    // raster position
    logic [prqw_pkg::COL_W-1:0] col_cnt_reg;
    logic [prqw_pkg::ROW_W-1:0] row_cnt_reg;
    logic [prqw_pkg::WX_W-1:0]  col_inc;
    logic [prqw_pkg::HX_W-1:0]  row_inc;
    logic                       row_end;
    logic                       frame_last;

    // handshake
    logic in_accept;
    logic s1_adv;

    // input stage
    logic                       s1_valid_reg;
    logic [PB-1:0]              s1_phase_reg;
    logic [prqw_pkg::COL_W-1:0] s1_col_reg;
    logic                       s1_rvalid_reg;
    logic                       s1_qvalid_reg;
    logic                       s1_fend_reg;
    logic [2*PB-1:0]            line_rd_reg;

    // line store: {row-2, row-1} per column
    logic [2*PB-1:0] line_mem [prqw_pkg::MAX_WIDTH];

    // window history, one and two columns back
    logic [PB-1:0] t1_reg, t2_reg, m1_reg, m2_reg, b1_reg, b2_reg;
    logic [PB-1:0] t0, m0, b0;

    // arithmetic
    logic signed [prqw_pkg::CURL_W-1:0] curl;
    logic signed [prqw_pkg::CURL_W-1:0] curl_biased;
    logic signed [prqw_pkg::CURL_W-1:0] curl_shift;
    logic [prqw_pkg::SAT_W-1:0]         q_sum;
    logic [prqw_pkg::Q_W-1:0]           q_sat;

    // output register
    logic                              out_valid_reg;
    logic signed [prqw_pkg::RES_W-1:0] residue_reg;
    logic                              residue_valid_reg;
    logic [prqw_pkg::Q_W-1:0]          quality_sum_reg;
    logic                              quality_valid_reg;
    logic                              frame_end_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= prqw_pkg::CFG_W'(prqw_pkg::FRAME_WIDTH_RST);
            frame_height_reg <= prqw_pkg::CFG_W'(prqw_pkg::FRAME_HEIGHT_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                prqw_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                prqw_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate frame geometry
    always_comb
    begin
        fw_x = prqw_pkg::WX_W'(frame_width_reg);
        fh_x = prqw_pkg::HX_W'(frame_height_reg);
        if (fw_x < prqw_pkg::WX_W'(prqw_pkg::MIN_DIM))
            w_eff = prqw_pkg::WX_W'(prqw_pkg::MIN_DIM);
        else if (fw_x > prqw_pkg::WX_W'(prqw_pkg::MAX_WIDTH))
            w_eff = prqw_pkg::WX_W'(prqw_pkg::MAX_WIDTH);
        else
            w_eff = fw_x;
        if (fh_x < prqw_pkg::HX_W'(prqw_pkg::MIN_DIM))
            h_eff = prqw_pkg::HX_W'(prqw_pkg::MIN_DIM);
        else if (fh_x > prqw_pkg::HX_W'(prqw_pkg::MAX_HEIGHT))
            h_eff = prqw_pkg::HX_W'(prqw_pkg::MAX_HEIGHT);
        else
            h_eff = fh_x;
    end

    assign col_inc    = prqw_pkg::WX_W'(col_cnt_reg) + prqw_pkg::WX_W'(1);
    assign row_inc    = prqw_pkg::HX_W'(row_cnt_reg) + prqw_pkg::HX_W'(1);
    assign row_end    = (col_inc >= w_eff);
    assign frame_last = row_end && (row_inc >= h_eff);

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    // advance raster position on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (in_accept)
        begin
            if (row_end)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= frame_last ? '0 : row_inc[prqw_pkg::ROW_W-1:0];
            end
            else
            begin
                col_cnt_reg <= col_inc[prqw_pkg::COL_W-1:0];
            end
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_phase_reg  <= phase[PB-1:0];
            s1_col_reg    <= col_cnt_reg;
            s1_rvalid_reg <= (row_cnt_reg != '0) && (col_cnt_reg != '0);
            s1_qvalid_reg <= (row_cnt_reg > prqw_pkg::ROW_W'(1))
                          && (col_cnt_reg > prqw_pkg::COL_W'(1));
            s1_fend_reg   <= frame_last;
        end
    end

    // line store: read at entry, write back as the pixel leaves the input stage
    always_ff @(posedge clk)
    begin
        if (in_accept)
            line_rd_reg <= line_mem[col_cnt_reg];
        if (s1_adv)
            line_mem[s1_col_reg] <= {m0, b0};
    end

    assign t0 = line_rd_reg[2*PB-1:PB];
    assign m0 = line_rd_reg[PB-1:0];
    assign b0 = s1_phase_reg;

    // shift the window one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            m1_reg <= '0;
            m2_reg <= '0;
            b1_reg <= '0;
            b2_reg <= '0;
        end
        else if (s1_adv)
        begin
            t2_reg <= t1_reg;
            t1_reg <= t0;
            m2_reg <= m1_reg;
            m1_reg <= m0;
            b2_reg <= b1_reg;
            b1_reg <= b0;
        end
    end

    // cell curl, divided by a full turn with truncation toward zero
    always_comb
    begin
        curl = prqw_pkg::CURL_W'(phase_delta(m0, m1_reg))
             - prqw_pkg::CURL_W'(phase_delta(b0, b1_reg))
             + prqw_pkg::CURL_W'(phase_delta(b0, m0))
             - prqw_pkg::CURL_W'(phase_delta(b1_reg, m1_reg));
        curl_biased = curl[prqw_pkg::CURL_W-1]
                    ? curl + prqw_pkg::CURL_W'((1 << PB) - 1)
                    : curl;
        curl_shift = curl_biased >>> PB;
    end

    // four squared second differences around the centre m1
    always_comb
    begin
        q_sum = prqw_pkg::SAT_W'(sd_square(m2_reg, m1_reg, m0))
              + prqw_pkg::SAT_W'(sd_square(t1_reg, m1_reg, b1_reg))
              + prqw_pkg::SAT_W'(sd_square(t2_reg, m1_reg, b0))
              + prqw_pkg::SAT_W'(sd_square(t0, m1_reg, b2_reg));
        if (q_sum > prqw_pkg::SAT_W'({prqw_pkg::Q_W{1'b1}}))
            q_sat = {prqw_pkg::Q_W{1'b1}};
        else
            q_sat = q_sum[prqw_pkg::Q_W-1:0];
    end

    // result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            residue_reg       <= s1_rvalid_reg ? curl_shift[prqw_pkg::RES_W-1:0] : '0;
            residue_valid_reg <= s1_rvalid_reg;
            quality_sum_reg   <= s1_qvalid_reg ? q_sat : '0;
            quality_valid_reg <= s1_qvalid_reg;
            frame_end_reg     <= s1_fend_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign residue       = residue_reg;
    assign residue_valid = residue_valid_reg;
    assign quality_sum   = quality_sum_reg;
    assign quality_valid = quality_valid_reg;
    assign frame_end     = frame_end_reg;

endmodule

### tb/tb.sv
// Testbench for the phase residue and second-difference quality window.
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic signed [prqw_pkg::RES_W-1:0] residue;
        logic                              residue_valid;
        logic [prqw_pkg::Q_W-1:0]          quality_sum;
        logic                              quality_valid;
        logic                              frame_end;
    } window_result_t;

    typedef enum int {
        FILL_UNIFORM,
        FILL_RAMP,
        FILL_EXTREME
    } fill_style_t;

    localparam int     PHASE_FULL  = 1 << prqw_pkg::PHASE_BITS;
    localparam longint Q_LIMIT     = (longint'(1) << prqw_pkg::Q_W) - 1;
    localparam int     QUIET_LIMIT = 2000;

    // 3x3 frame with one positive and one negative vortex
    localparam logic [prqw_pkg::PHASE_IN_W-1:0] VORTEX_FRAME [9] = '{
        16'd0,     16'd16384, 16'd32768,
        16'd49152, 16'd32768, 16'd16384,
        16'd0,     16'd16384, 16'd65535
    };
    localparam logic [prqw_pkg::PHASE_IN_W-1:0] EXTREME_FRAME [9] = '{
        16'hffff, 16'h0000, 16'h8000,
        16'h7fff, 16'hffff, 16'h0000,
        16'h8000, 16'h7fff, 16'hffff
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [prqw_pkg::PHASE_IN_W-1:0]   phase = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [prqw_pkg::RES_W-1:0] residue;
    logic                              residue_valid;
    logic [prqw_pkg::Q_W-1:0]          quality_sum;
    logic                              quality_valid;
    logic                              frame_end;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [prqw_pkg::IDX_W-1:0]        cfg_index = '0;
    logic [prqw_pkg::CFG_W-1:0]        cfg_data = '0;

    // predictor state: two previous rows and the last two window columns
    logic [prqw_pkg::PHASE_BITS-1:0] line_row2 [prqw_pkg::MAX_WIDTH];
    logic [prqw_pkg::PHASE_BITS-1:0] line_row1 [prqw_pkg::MAX_WIDTH];
    logic [prqw_pkg::PHASE_BITS-1:0] top1 = '0, top2 = '0, mid1 = '0, mid2 = '0;
    logic [prqw_pkg::PHASE_BITS-1:0] bot1 = '0, bot2 = '0;
    int                              col_pos = 0;
    int                              row_pos = 0;
    logic [prqw_pkg::CFG_W-1:0]      width_reg = prqw_pkg::CFG_W'(prqw_pkg::FRAME_WIDTH_RST);
    logic [prqw_pkg::CFG_W-1:0]      height_reg = prqw_pkg::CFG_W'(prqw_pkg::FRAME_HEIGHT_RST);

    logic [prqw_pkg::PHASE_IN_W-1:0] pixel_q [$];
    window_result_t                  pending_results [$];

    int idle_pct = 0;
    int in_gap_left = 0;
    int out_gap_left = 0;
    int ramp_row = 0, ramp_col = 0, ramp_noise = 0;
    int fail_count = 0;
    int beats_checked = 0;
    int frames_seen = 0;
    int reg_writes = 0;
    int pos_residues = 0, neg_residues = 0;
    int quiet_cycles = 0;

    phase_residue_quality_window i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .phase         (phase),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .residue       (residue),
        .residue_valid (residue_valid),
        .quality_sum   (quality_sum),
        .quality_valid (quality_valid),
        .frame_end     (frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int clamp_dim(input int v, input int hi);
        return (v < prqw_pkg::MIN_DIM) ? prqw_pkg::MIN_DIM : ((v > hi) ? hi : v);
    endfunction

    function automatic int wrap_phase(input int v);
        logic signed [prqw_pkg::PHASE_BITS-1:0] t;
        t = v[prqw_pkg::PHASE_BITS-1:0];
        return t;
    endfunction

    function automatic longint squared_second_diff(input int a, input int b, input int c);
        int d;
        d = wrap_phase(wrap_phase(c - b) - wrap_phase(b - a));
        return longint'(d) * d;
    endfunction

    function automatic void add_pixel(input logic [prqw_pkg::PHASE_IN_W-1:0] px);
        pixel_q = {pixel_q, px};
    endfunction

    // Advance the window by one pixel and queue the result it gives.
    function automatic void compute_window_result(input logic [prqw_pkg::PHASE_IN_W-1:0] px);
        int w, h, idx, t0, m0, b0, t1, t2, m1, m2, b1, b2, curl;
        longint q;
        window_result_t r;
        w = clamp_dim(width_reg, prqw_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, prqw_pkg::MAX_HEIGHT);
        idx = col_pos % prqw_pkg::MAX_WIDTH;
        t0 = int'(line_row2[idx]);
        m0 = int'(line_row1[idx]);
        b0 = int'(px[prqw_pkg::PHASE_BITS-1:0]);
        t1 = int'(top1);
        t2 = int'(top2);
        m1 = int'(mid1);
        m2 = int'(mid2);
        b1 = int'(bot1);
        b2 = int'(bot2);
        r.residue = '0;
        r.quality_sum = '0;
        r.residue_valid = (row_pos >= 1) && (col_pos >= 1);
        r.quality_valid = (row_pos >= 2) && (col_pos >= 2);
        if (r.residue_valid)
        begin
            // loop sum around the cell is an exact multiple of a full turn
            curl = wrap_phase(m0 - m1) - wrap_phase(b0 - b1)
                 + wrap_phase(b0 - m0) - wrap_phase(b1 - m1);
            r.residue = prqw_pkg::RES_W'(curl / PHASE_FULL);
        end
        if (r.quality_valid)
        begin
            q = squared_second_diff(m2, m1, m0) + squared_second_diff(t1, m1, b1)
              + squared_second_diff(t2, m1, b0) + squared_second_diff(t0, m1, b2);
            if (q > Q_LIMIT)
                q = Q_LIMIT;
            r.quality_sum = q[prqw_pkg::Q_W-1:0];
        end
        line_row2[idx] = m0[prqw_pkg::PHASE_BITS-1:0];
        line_row1[idx] = b0[prqw_pkg::PHASE_BITS-1:0];
        top2 = top1;
        top1 = t0[prqw_pkg::PHASE_BITS-1:0];
        mid2 = mid1;
        mid1 = m0[prqw_pkg::PHASE_BITS-1:0];
        bot2 = bot1;
        bot1 = b0[prqw_pkg::PHASE_BITS-1:0];
        r.frame_end = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = r.frame_end ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
        pending_results = {pending_results, r};
    endfunction

    function automatic int pixels_to_frame_end();
        int w, h, rest;
        w = clamp_dim(width_reg, prqw_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, prqw_pkg::MAX_HEIGHT);
        rest = (col_pos + 1 >= w) ? 1 : w - col_pos;
        if (row_pos + 1 < h)
            rest += (h - row_pos - 1) * w;
        return rest;
    endfunction

    function automatic logic [prqw_pkg::PHASE_IN_W-1:0] make_pixel(input fill_style_t style,
                                                                   input int r, input int c);
        int v;
        case (style)
            FILL_RAMP:
                v = ramp_row * r + ramp_col * c + int'($urandom_range(0, ramp_noise));
            FILL_EXTREME:
                case ($urandom_range(0, 4))
                    0: v = 0;
                    1: v = PHASE_FULL - 1;
                    2: v = PHASE_FULL / 2;
                    3: v = PHASE_FULL / 2 - 1;
                    default: v = int'($urandom_range(0, PHASE_FULL - 1));
                endcase
            default:
                v = int'($urandom_range(0, PHASE_FULL - 1));
        endcase
        return v[prqw_pkg::PHASE_IN_W-1:0];
    endfunction

    // Queue pixels up to the end of the current frame; returns their number.
    function automatic int queue_frame(input fill_style_t style);
        int n, w;
        n = pixels_to_frame_end();
        w = clamp_dim(width_reg, prqw_pkg::MAX_WIDTH);
        ramp_row = $urandom_range(0, 1) ? $urandom_range(0, 6000)
                                        : PHASE_FULL - $urandom_range(0, 6000);
        ramp_col = $urandom_range(0, 1) ? $urandom_range(0, 6000)
                                        : PHASE_FULL - $urandom_range(0, 6000);
        ramp_noise = $urandom_range(0, 3000);
        for (int k = 0; k < n; k++)
            add_pixel(make_pixel(style, k / w, k % w));
        return n;
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [prqw_pkg::Q_W:0] want,
                                        input logic signed [prqw_pkg::Q_W:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        window_result_t r;
        if (pending_results.size() == 0)
        begin
            $error("result beat with no pixel pending");
            fail_count++;
            return;
        end
        r = pending_results.pop_front();
        check_field("residue", r.residue, residue);
        check_field("residue_valid", r.residue_valid, residue_valid);
        check_field("quality_sum", r.quality_sum, quality_sum);
        check_field("quality_valid", r.quality_valid, quality_valid);
        check_field("frame_end", r.frame_end, frame_end);
        beats_checked++;
        if (frame_end === 1'b1)
            frames_seen++;
        if (residue === 3'sd1)
            pos_residues++;
        if (residue === -3'sd1)
            neg_residues++;
    endfunction

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                compute_window_result(phase);
            // hold a stalled beat as it is
            if (!(in_valid && in_stall))
            begin
                if (in_gap_left > 0)
                begin
                    in_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pixel_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if ($urandom_range(1, 100) <= idle_pct)
                begin
                    in_gap_left = $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    phase <= pixel_q.pop_front();
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (out_gap_left > 0)
            begin
                out_gap_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(1, 100) <= idle_pct)
            begin
                out_gap_left = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input prqw_pkg::reg_index_t idx,
                             input logic [prqw_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            prqw_pkg::REG_FRAME_WIDTH:  width_reg = value;
            prqw_pkg::REG_FRAME_HEIGHT: height_reg = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Drain every queued pixel and result, then let the pipeline settle.
    task automatic wait_idle();
        while (pixel_q.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_frames(input int budget, input bit quiet_tail);
        int done_px;
        logic [prqw_pkg::CFG_W-1:0] w_val, h_val;
        done_px = 0;
        while (done_px < budget)
        begin
            case ($urandom_range(0, 9))
                0:       w_val = prqw_pkg::CFG_W'($urandom_range(0, 2));
                1, 2:    w_val = prqw_pkg::CFG_W'($urandom_range(25, 64));
                default: w_val = prqw_pkg::CFG_W'($urandom_range(3, 24));
            endcase
            h_val = ($urandom_range(0, 9) == 0) ? prqw_pkg::CFG_W'($urandom_range(0, 2))
                                                : prqw_pkg::CFG_W'($urandom_range(3, 10));
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 5;
                default: idle_pct = 20;
            endcase
            if (quiet_tail && budget - done_px < 150)
                idle_pct = 0;
            write_reg(prqw_pkg::REG_FRAME_WIDTH, w_val);
            write_reg(prqw_pkg::REG_FRAME_HEIGHT, h_val);
            done_px += queue_frame(fill_style_t'($urandom_range(0, 2)));
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct = 10;
        write_reg(prqw_pkg::REG_FRAME_WIDTH, 11'd3);
        write_reg(prqw_pkg::REG_FRAME_HEIGHT, 11'd3);
        foreach (VORTEX_FRAME[k])
            add_pixel(VORTEX_FRAME[k]);
        foreach (EXTREME_FRAME[k])
            add_pixel(EXTREME_FRAME[k]);
        wait_idle();

        run_frames(250, 1'b0);

        // shrink height and then width in the middle of a frame
        idle_pct = 15;
        write_reg(prqw_pkg::REG_FRAME_WIDTH, 11'd8);
        write_reg(prqw_pkg::REG_FRAME_HEIGHT, 11'd6);
        repeat (28) add_pixel(make_pixel(FILL_UNIFORM, 0, 0));
        wait_idle();
        write_reg(prqw_pkg::REG_FRAME_HEIGHT, 11'd2);
        add_pixel(make_pixel(FILL_UNIFORM, 0, 0));
        wait_idle();
        write_reg(prqw_pkg::REG_FRAME_WIDTH, 11'd4);
        void'(queue_frame(FILL_UNIFORM));
        wait_idle();

        // register values beyond the legal range: a long row cut short by a narrow width
        write_reg(prqw_pkg::REG_FRAME_WIDTH, 11'd2047);
        write_reg(prqw_pkg::REG_FRAME_HEIGHT, 11'd0);
        repeat (70) add_pixel(make_pixel(FILL_EXTREME, 0, 0));
        wait_idle();
        write_reg(prqw_pkg::REG_FRAME_WIDTH, 11'd1);
        void'(queue_frame(FILL_RAMP));
        wait_idle();

        // tall frame cut short by a smaller height
        write_reg(prqw_pkg::REG_FRAME_WIDTH, 11'd0);
        write_reg(prqw_pkg::REG_FRAME_HEIGHT, 11'd2047);
        repeat (36) add_pixel(make_pixel(FILL_UNIFORM, 0, 0));
        wait_idle();
        write_reg(prqw_pkg::REG_FRAME_HEIGHT, 11'd5);
        void'(queue_frame(FILL_EXTREME));
        wait_idle();

        run_frames(250, 1'b1);

        $display("checked %0d result beats over %0d frames after %0d register writes",
                 beats_checked, frames_seen, reg_writes);
        $display("vortices seen: %0d positive, %0d negative", pos_residues, neg_residues);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### filelist.f
rtl/prqw_pkg.sv
rtl/phase_residue_quality_window.sv
tb/tb.sv
